// ===== design/rmq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants, types and codes for the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int SHIFT     = FRAC_BITS - 2;
  localparam int M_W       = 16;                 // matrix entry / component width
  localparam int D_W       = M_W + 1;            // entry sum or difference
  localparam int T_W       = M_W + 2;            // trace
  localparam int R_W       = M_W + 1;            // clamped radicand
  localparam int N_W       = R_W + SHIFT;        // sqrt operand
  localparam int SQ_STEPS  = (N_W + 1) / 2;      // result bits of the root
  localparam int SQ_W      = 2 * SQ_STEPS + 1;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int STEPS_PER = 3;                  // iterations per pipe stage
  localparam int SQ_STG    = (SQ_STEPS + STEPS_PER - 1) / STEPS_PER;
  localparam int Q_BITS    = M_W - 1;            // quotient bits below saturation
  localparam int DEN_W     = ROOT_W + 1;
  localparam int NUM_W     = D_W + SHIFT + 2;
  localparam int DV_STG    = 1 + (Q_BITS + STEPS_PER - 1) / STEPS_PER;

  typedef enum logic [1:0] {
    PC_TRACE = 2'd0,
    PC_X     = 2'd1,
    PC_Y     = 2'd2,
    PC_Z     = 2'd3
  } pivot_t;

  // Sideband that travels alongside the root calculation
  typedef struct packed {
    logic signed [D_W-1:0] d0;
    logic signed [D_W-1:0] d1;
    logic signed [D_W-1:0] d2;
    pivot_t                pc;
  } side_t;

  // Divider results for the three off-pivot components
  typedef struct packed {
    logic [2:0][Q_BITS-1:0] q;
    logic [2:0]             ovf;
    logic [2:0]             neg;
    logic [ROOT_W-1:0]      root;
    pivot_t                 pc;
  } dv_res_t;

endpackage

`default_nettype wire

// ===== design/rmq_select.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_select
// Branch selection, radicand and entry sums, one register stage.
// ----------------------------------------------------------------------------
module rmq_select (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [9*rmq_pkg::M_W-1:0]          in_mat,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [rmq_pkg::N_W-1:0]                 out_n,
  output rmq_pkg::side_t                          out_side
);

  logic signed [rmq_pkg::D_W-1:0] e [9];
  logic signed [rmq_pkg::T_W-1:0] trace;
  logic signed [rmq_pkg::T_W:0]   rad;
  logic [rmq_pkg::N_W-1:0]        n_next;
  rmq_pkg::side_t                 side_next;
  logic                           en;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = rmq_pkg::D_W'($signed(in_mat[i*rmq_pkg::M_W +: rmq_pkg::M_W]));
    end
    trace = rmq_pkg::T_W'(e[0]) + rmq_pkg::T_W'(e[4]) + rmq_pkg::T_W'(e[8]);
    if (trace > 0) begin
      side_next.pc = rmq_pkg::PC_TRACE;
      rad          = (rmq_pkg::T_W+1)'(trace);
      side_next.d0 = e[7] - e[5];
      side_next.d1 = e[2] - e[6];
      side_next.d2 = e[3] - e[1];
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      side_next.pc = rmq_pkg::PC_X;
      rad = (rmq_pkg::T_W+1)'(e[0]) - (rmq_pkg::T_W+1)'(e[4]) - (rmq_pkg::T_W+1)'(e[8]);
      side_next.d0 = e[3] + e[1];
      side_next.d1 = e[2] + e[6];
      side_next.d2 = e[7] - e[5];
    end else if (e[4] > e[8]) begin
      side_next.pc = rmq_pkg::PC_Y;
      rad = (rmq_pkg::T_W+1)'(e[4]) - (rmq_pkg::T_W+1)'(e[0]) - (rmq_pkg::T_W+1)'(e[8]);
      side_next.d0 = e[3] + e[1];
      side_next.d1 = e[7] + e[5];
      side_next.d2 = e[2] - e[6];
    end else begin
      side_next.pc = rmq_pkg::PC_Z;
      rad = (rmq_pkg::T_W+1)'(e[8]) - (rmq_pkg::T_W+1)'(e[0]) - (rmq_pkg::T_W+1)'(e[4]);
      side_next.d0 = e[2] + e[6];
      side_next.d1 = e[7] + e[5];
      side_next.d2 = e[3] - e[1];
    end
    rad = rad + (rmq_pkg::T_W+1)'(1 << rmq_pkg::FRAC_BITS);
    // negative radicand clamps to zero
    if (rad < 0) begin
      n_next = '0;
    end else begin
      n_next = {rad[rmq_pkg::R_W-1:0], {rmq_pkg::SHIFT{1'b0}}};
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_n    <= n_next;
      out_side <= side_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/rmq_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined digit-by-digit integer square root, a few iterations per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rmq_pkg::N_W-1:0]      in_n,
  input  wire rmq_pkg::side_t               in_side,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rmq_pkg::ROOT_W-1:0]        out_root,
  output rmq_pkg::side_t                    out_side
);

  typedef struct packed {
    logic [rmq_pkg::SQ_W-1:0] num;
    logic [rmq_pkg::SQ_W-1:0] res;
    rmq_pkg::side_t           side;
  } sq_t;

  sq_t  stg  [rmq_pkg::SQ_STG];
  sq_t  nxt  [rmq_pkg::SQ_STG];
  logic v    [rmq_pkg::SQ_STG];
  logic src_v[rmq_pkg::SQ_STG];
  logic en   [rmq_pkg::SQ_STG];

  always_comb begin
    sq_t                      t;
    logic [rmq_pkg::SQ_W-1:0] bitv;
    int                       k;
    for (int i = 0; i < rmq_pkg::SQ_STG; i++) begin
      if (i == 0) begin
        t.num  = rmq_pkg::SQ_W'(in_n);
        t.res  = '0;
        t.side = in_side;
      end else begin
        t = stg[i-1];
      end
      for (int j = 0; j < rmq_pkg::STEPS_PER; j++) begin
        k = i * rmq_pkg::STEPS_PER + j;
        if (k < rmq_pkg::SQ_STEPS) begin
          bitv = rmq_pkg::SQ_W'(1) << (2 * (rmq_pkg::SQ_STEPS - 1 - k));
          if (t.num >= t.res + bitv) begin
            t.num = t.num - (t.res + bitv);
            t.res = (t.res >> 1) + bitv;
          end else begin
            t.res = t.res >> 1;
          end
        end
      end
      nxt[i] = t;
    end
  end

  always_comb begin
    for (int i = rmq_pkg::SQ_STG - 1; i >= 0; i--) begin
      if (i == rmq_pkg::SQ_STG - 1) begin
        en[i] = !v[i] || out_ready;
      end else begin
        en[i] = !v[i] || en[i+1];
      end
    end
    for (int i = 0; i < rmq_pkg::SQ_STG; i++) begin
      if (i == 0) begin
        src_v[i] = in_valid;
      end else begin
        src_v[i] = v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rmq_pkg::SQ_STG; i++) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= src_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rmq_pkg::SQ_STG; i++) begin
      if (en[i]) begin
        stg[i] <= nxt[i];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[rmq_pkg::SQ_STG-1];
  assign out_root  = stg[rmq_pkg::SQ_STG-1].res[rmq_pkg::ROOT_W-1:0];
  assign out_side  = stg[rmq_pkg::SQ_STG-1].side;

endmodule

`default_nettype wire

// ===== design/rmq_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider for the rounded scaled quotients.
// ----------------------------------------------------------------------------
module rmq_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rmq_pkg::ROOT_W-1:0]   in_root,
  input  wire rmq_pkg::side_t               in_side,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output rmq_pkg::dv_res_t                  out_res
);

  typedef struct packed {
    logic [2:0][rmq_pkg::Q_BITS-1:0] low;
    logic [2:0][rmq_pkg::DEN_W-1:0]  rem;
    logic [2:0][rmq_pkg::Q_BITS-1:0] q;
    logic [2:0]                      ovf;
    logic [2:0]                      neg;
    logic [rmq_pkg::DEN_W-1:0]       den;
    logic [rmq_pkg::ROOT_W-1:0]      root;
    rmq_pkg::pivot_t                 pc;
  } dv_t;

  dv_t  stg  [rmq_pkg::DV_STG];
  dv_t  nxt  [rmq_pkg::DV_STG];
  logic v    [rmq_pkg::DV_STG];
  logic src_v[rmq_pkg::DV_STG];
  logic en   [rmq_pkg::DV_STG];

  always_comb begin
    dv_t                             t;
    logic signed [rmq_pkg::D_W-1:0]  d [3];
    logic signed [rmq_pkg::D_W:0]    dm;
    logic [rmq_pkg::D_W-1:0]         mag;
    logic [rmq_pkg::NUM_W-1:0]       num;
    logic [rmq_pkg::DEN_W:0]         tr;
    int                              k;
    d[0] = in_side.d0;
    d[1] = in_side.d1;
    d[2] = in_side.d2;
    // prep: numerator 2*|d|*2^SHIFT + p over 2p, saturation test up front
    t = '0;
    t.den  = {in_root, 1'b0};
    t.root = in_root;
    t.pc   = in_side.pc;
    for (int l = 0; l < 3; l++) begin
      t.neg[l] = d[l][rmq_pkg::D_W-1];
      dm       = t.neg[l] ? -(rmq_pkg::D_W+1)'(d[l]) : (rmq_pkg::D_W+1)'(d[l]);
      mag      = dm[rmq_pkg::D_W-1:0];
      num      = {mag, {rmq_pkg::SHIFT{1'b0}}, 1'b0} + rmq_pkg::NUM_W'(in_root);
      t.ovf[l] = num[rmq_pkg::NUM_W-1:rmq_pkg::Q_BITS] >= t.den;
      t.rem[l] = num[rmq_pkg::NUM_W-1:rmq_pkg::Q_BITS];
      t.low[l] = num[rmq_pkg::Q_BITS-1:0];
    end
    nxt[0] = t;
    for (int i = 1; i < rmq_pkg::DV_STG; i++) begin
      t = stg[i-1];
      for (int j = 0; j < rmq_pkg::STEPS_PER; j++) begin
        k = (i - 1) * rmq_pkg::STEPS_PER + j;
        if (k < rmq_pkg::Q_BITS) begin
          for (int l = 0; l < 3; l++) begin
            tr       = {t.rem[l], t.low[l][rmq_pkg::Q_BITS-1]};
            t.low[l] = t.low[l] << 1;
            if (tr >= (rmq_pkg::DEN_W+1)'(t.den)) begin
              tr       = tr - (rmq_pkg::DEN_W+1)'(t.den);
              t.q[l]   = {t.q[l][rmq_pkg::Q_BITS-2:0], 1'b1};
            end else begin
              t.q[l]   = {t.q[l][rmq_pkg::Q_BITS-2:0], 1'b0};
            end
            t.rem[l] = tr[rmq_pkg::DEN_W-1:0];
          end
        end
      end
      nxt[i] = t;
    end
  end

  always_comb begin
    for (int i = rmq_pkg::DV_STG - 1; i >= 0; i--) begin
      if (i == rmq_pkg::DV_STG - 1) begin
        en[i] = !v[i] || out_ready;
      end else begin
        en[i] = !v[i] || en[i+1];
      end
    end
    for (int i = 0; i < rmq_pkg::DV_STG; i++) begin
      if (i == 0) begin
        src_v[i] = in_valid;
      end else begin
        src_v[i] = v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rmq_pkg::DV_STG; i++) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= src_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rmq_pkg::DV_STG; i++) begin
      if (en[i]) begin
        stg[i] <= nxt[i];
      end
    end
  end

  assign in_ready     = en[0];
  assign out_valid    = v[rmq_pkg::DV_STG-1];
  assign out_res.q    = stg[rmq_pkg::DV_STG-1].q;
  assign out_res.ovf  = stg[rmq_pkg::DV_STG-1].ovf;
  assign out_res.neg  = stg[rmq_pkg::DV_STG-1].neg;
  assign out_res.root = stg[rmq_pkg::DV_STG-1].root;
  assign out_res.pc   = stg[rmq_pkg::DV_STG-1].pc;

endmodule

`default_nettype wire

// ===== design/rotation_matrix_to_quaternion.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd's method matrix to unit quaternion, Q2.14, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline: 1 select, 5 square root, 6 divide and 1 output stage between
//   the input transaction and the result on m_tvalid.
// Throughput: one matrix per cycle; each stage holds its own valid bit and
//   stalls only when the stage after it is full, so bubbles close up.
// Reset: synchronous rst clears every valid bit; data registers keep junk.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, low first)
  input  wire logic [143:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each, low first)
  output logic [63:0]       m_tdata,
  // pivot_case [1:0], degenerate [2]
  output logic [2:0]        m_tuser
);

  logic                          sel_valid, sel_ready;
  logic [rmq_pkg::N_W-1:0]       sel_n;
  rmq_pkg::side_t                sel_side;
  logic                          sq_valid, sq_ready;
  logic [rmq_pkg::ROOT_W-1:0]    sq_root;
  rmq_pkg::side_t                sq_side;
  logic                          dv_valid, dv_ready;
  rmq_pkg::dv_res_t              dv_res;
  logic                          en_out;
  logic [rmq_pkg::M_W-1:0]       comp [3];
  logic [rmq_pkg::M_W-1:0]       piv;
  logic [4*rmq_pkg::M_W-1:0]     data_next;
  logic                          degen;

  // stage 1: branch choice, radicand, entry sums
  rmq_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mat    (s_tdata),
    .out_valid (sel_valid),
    .out_ready (sel_ready),
    .out_n     (sel_n),
    .out_side  (sel_side)
  );

  // pivot = floor(sqrt(r * 2^(FRAC_BITS-2)))
  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_n      (sel_n),
    .in_side   (sel_side),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // three off-pivot components, rounded half away from zero
  rmq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_res   (dv_res)
  );

  // sign and saturation, then place components by branch
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_res.ovf[l]) begin
        comp[l] = dv_res.neg[l] ? {1'b1, {(rmq_pkg::M_W-1){1'b0}}}
                                : {1'b0, {(rmq_pkg::M_W-1){1'b1}}};
      end else if (dv_res.neg[l]) begin
        comp[l] = -{1'b0, dv_res.q[l]};
      end else begin
        comp[l] = {1'b0, dv_res.q[l]};
      end
    end
    piv   = rmq_pkg::M_W'(dv_res.root);
    degen = (dv_res.root == '0);
    case (dv_res.pc)
      rmq_pkg::PC_TRACE: data_next = {comp[2], comp[1], comp[0], piv};
      rmq_pkg::PC_X:     data_next = {comp[1], comp[0], piv, comp[2]};
      rmq_pkg::PC_Y:     data_next = {comp[1], piv, comp[0], comp[2]};
      rmq_pkg::PC_Z:     data_next = {piv, comp[1], comp[0], comp[2]};
      default:           data_next = '0;
    endcase
    // zero pivot: every component reads zero
    if (degen) begin
      data_next = '0;
    end
  end

  // output register: takes a new result when empty or when the held one leaves
  assign en_out   = !m_tvalid || m_tready;
  assign dv_ready = en_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      m_tdata <= data_next;
      m_tuser <= {degen, dv_res.pc};
    end
  end

endmodule

`default_nettype wire

// ===== design/rmq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the matrix to quaternion block, bound to the top.
// ----------------------------------------------------------------------------
module rmq_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [143:0] s_tdata,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [63:0]  m_tdata,
  input wire logic [2:0]   m_tuser
);

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("input changed while stalled");

  // a stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tdata == 64'd0)
    else $error("degenerate result with nonzero components");

  // trace branch: w is the pivot and strictly positive
  a_wpos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] && m_tuser[1:0] == rmq_pkg::PC_TRACE
      |-> !m_tdata[15] && m_tdata[15:0] != 16'd0)
    else $error("trace pivot not positive");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== test/rotation_matrix_to_quaternion_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Streams rotation matrices and raw bit patterns through the quaternion
// pipeline under random sender gaps and receiver stalls. Every result is
// checked field by field against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;

  localparam int ONE_Q   = 1 << rmq_pkg::FRAC_BITS;
  localparam int N_RAND  = 550;
  localparam int WDOG    = 20000;

  typedef struct packed {
    logic [15:0]     qw;
    logic [15:0]     qx;
    logic [15:0]     qy;
    logic [15:0]     qz;
    rmq_pkg::pivot_t pc;
    logic            degen;
  } quat_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [143:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic [2:0]   m_tuser;

  logic [143:0] pending_mats[$];   // matrices waiting to be driven
  quat_t        expected_quats[$]; // predictions in acceptance order
  int           mismatches;
  int           idle_cycles;
  bit           stim_done;
  bit           hold_off;          // sender waits for the pipe to drain
  int           burst_left;
  int           gap_left;
  int           stall_phase;

  rotation_matrix_to_quaternion DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, floor
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // d * 2^(FRAC_BITS-2) / p, magnitude rounded half away from zero
  function automatic logic [15:0] scaled_quot(input longint d, input longint unsigned p);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? -d : d;
    q   = (2 * (mag << rmq_pkg::SHIFT) + p) / (2 * p);
    if (q > 65536) q = 65536;
    return clip16((d < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_t predict_quat(input logic [143:0] mat);
    longint m[9];
    longint trace, rad, d0, d1, d2;
    longint unsigned p;
    logic [15:0] comp[4];
    int piv, o0, o1, o2;
    quat_t res;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[16*i +: 16]));
    trace = m[0] + m[4] + m[8];
    if (trace > 0) begin
      res.pc = rmq_pkg::PC_TRACE; rad = trace + ONE_Q;
      piv = 0; o0 = 1; o1 = 2; o2 = 3;
      d0 = m[7] - m[5]; d1 = m[2] - m[6]; d2 = m[3] - m[1];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      res.pc = rmq_pkg::PC_X; rad = m[0] - m[4] - m[8] + ONE_Q;
      piv = 1; o0 = 2; o1 = 3; o2 = 0;
      d0 = m[3] + m[1]; d1 = m[2] + m[6]; d2 = m[7] - m[5];
    end else if (m[4] > m[8]) begin
      res.pc = rmq_pkg::PC_Y; rad = m[4] - m[0] - m[8] + ONE_Q;
      piv = 2; o0 = 1; o1 = 3; o2 = 0;
      d0 = m[3] + m[1]; d1 = m[7] + m[5]; d2 = m[2] - m[6];
    end else begin
      res.pc = rmq_pkg::PC_Z; rad = m[8] - m[0] - m[4] + ONE_Q;
      piv = 3; o0 = 1; o1 = 2; o2 = 0;
      d0 = m[2] + m[6]; d1 = m[7] + m[5]; d2 = m[3] - m[1];
    end
    if (rad < 0) rad = 0;
    p = root_floor(longint'(rad) << rmq_pkg::SHIFT);
    for (int i = 0; i < 4; i++) comp[i] = '0;
    res.degen = (p == 0);
    if (p != 0) begin
      comp[piv] = clip16(longint'(p));
      comp[o0]  = scaled_quot(d0, p);
      comp[o1]  = scaled_quot(d1, p);
      comp[o2]  = scaled_quot(d2, p);
    end
    res.qw = comp[0]; res.qx = comp[1]; res.qy = comp[2]; res.qz = comp[3];
    return res;
  endfunction

  function automatic logic [143:0] pack_mat(input int e[9]);
    logic [143:0] v;
    for (int i = 0; i < 9; i++) v[16*i +: 16] = e[i][15:0];
    return v;
  endfunction

  // Near-rotation: a diagonal biased towards one pivot plus off-diagonals in -16384..16384
  function automatic logic [143:0] rand_rotation();
    int e[9];
    int lead;
    lead = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) e[i] = int'($urandom_range(0, 32768)) - 16384;
    if (lead == 0) begin
      e[0] = $urandom_range(0, 16384); e[4] = $urandom_range(0, 16384);
      e[8] = $urandom_range(0, 16384);
    end else begin
      for (int i = 0; i < 3; i++) e[4*i] = -int'($urandom_range(0, 16384));
      e[4*(lead-1)] = $urandom_range(0, 16384);
      // exact diagonal ties every so often
      if ($urandom_range(0, 7) == 0) e[4*((lead) % 3)] = e[4*(lead-1)];
    end
    return pack_mat(e);
  endfunction

  function automatic logic [143:0] rand_raw();
    logic [143:0] v;
    for (int i = 0; i < 9; i++) v[16*i +: 16] = $urandom;
    return v;
  endfunction

  // ---- stimulus ----
  initial begin
    int e[9];
    rst = 1'b1;
    // Directed: identity, sign extremes, every pivot, ties
    e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};       pending_mats.push_back(pack_mat(e));
    e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};     pending_mats.push_back(pack_mat(e));
    e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};     pending_mats.push_back(pack_mat(e));
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};     pending_mats.push_back(pack_mat(e));
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                   pending_mats.push_back(pack_mat(e));
    e = '{-5000, 100, 0, 0, -5000, 0, 0, 0, -5000};     pending_mats.push_back(pack_mat(e));
    e = '{-1000, 7, 8, 9, -1000, 3, 2, 1, -3000};       pending_mats.push_back(pack_mat(e));
    e = '{-3000, 7, 8, 9, -1000, 3, 2, 1, -1000};       pending_mats.push_back(pack_mat(e));
    e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    pending_mats.push_back(pack_mat(e));
    e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    pending_mats.push_back(pack_mat(e));
    e = '{32767, -32768, 32767, 32767, -32768, -32768, -32768, 32767, -32768};
    pending_mats.push_back(pack_mat(e));
    e = '{-32768, 32767, -32768, -32768, -32768, 32767, 32767, -32768, 32767};
    pending_mats.push_back(pack_mat(e));
    // mixed-sign diagonals, one trace pivot and one z pivot
    e = '{-32768, 5, 6, 7, 32767, 8, 9, 10, 32767};     pending_mats.push_back(pack_mat(e));
    e = '{-16384, 5, 6, 7, -16384, 8, 9, 10, 32767};    pending_mats.push_back(pack_mat(e));
    // large off-diagonals under a z pivot, then single-entry and all-negative diagonals
    e = '{-8192, 30000, -30000, -30000, -8192, 30000, 30000, 1, 0};
    pending_mats.push_back(pack_mat(e));
    e = '{1, 0, 0, 0, 0, 0, 0, 0, 0};                   pending_mats.push_back(pack_mat(e));
    e = '{-1, 0, 0, 0, 0, 0, 0, 0, 0};                  pending_mats.push_back(pack_mat(e));
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};    pending_mats.push_back(pack_mat(e));
    for (int n = 0; n < N_RAND; n++)
      pending_mats.push_back(($urandom_range(0, 3) == 0) ? rand_raw() : rand_rotation());
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // ---- driver: bursts and gaps, one drain pause midway ----
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
      hold_off   <= 1'b0;
      stim_done  <= 1'b0;
    end else begin
      logic fire;
      logic [143:0] nxt;
      fire = s_tvalid && s_tready;
      if (fire) begin
        expected_quats.push_back(predict_quat(s_tdata));
        void'(pending_mats.pop_front());
        if (pending_mats.size() == N_RAND / 2) hold_off <= 1'b1;
      end
      if (s_tvalid && !fire) begin
        // keep the current transaction on the bus
      end else if (hold_off && (fire || expected_quats.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else if (hold_off) begin
        hold_off <= 1'b0;
        s_tvalid <= 1'b0;
      end else if (pending_mats.size() == 0) begin
        s_tvalid  <= 1'b0;
        stim_done <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else begin
        nxt      = pending_mats[0];
        s_tvalid <= 1'b1;
        s_tdata  <= nxt;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---- receiver: own stall pattern, plus the scoreboard ----
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      stall_phase <= 0;
      mismatches  <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      // long ready stretches alternate with random stalls
      if ((stall_phase / 64) % 3 == 0) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 3) != 0);
      if (m_tvalid && m_tready) begin
        quat_t want;
        quat_t got;
        got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                rmq_pkg::pivot_t'(m_tuser[1:0]), m_tuser[2]};
        if (expected_quats.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_quats.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display({"result mismatch: want w%h x%h y%h z%h pc%0d dg%b,",
                        " got w%h x%h y%h z%h pc%0d dg%b"},
                       want.qw, want.qx, want.qy, want.qz, want.pc, want.degen,
                       got.qw, got.qx, got.qy, got.qz, got.pc, got.degen);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  // ---- end of run and watchdog ----
  initial begin
    idle_cycles = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (stim_done && expected_quats.size() == 0) begin
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_quats.size() == 0) begin
          $display("SCOREBOARD CLEAN");
        end else begin
          $display("SCOREBOARD MISMATCH");
        end
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rotation_matrix_to_quaternion.f =====
design/rmq_pkg.sv
design/rmq_select.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion.sv
design/rmq_checker.sv
test/rotation_matrix_to_quaternion_test.sv
